// ----- sv/twm_pkg.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_pkg
// Types and fixed constants shared by the text mode terminal writer.
// ----------------------------------------------------------------------------
package twm_pkg;

  localparam int COL_W  = 7;
  localparam int ROW_W  = 5;
  localparam int CHAR_W = 8;
  localparam int CELL_W = 16;

  localparam logic [1:0] CMD_PUT   = 2'd0;
  localparam logic [1:0] CMD_WRITE = 2'd1;
  localparam logic [1:0] CMD_READ  = 2'd2;

  localparam logic [CHAR_W-1:0] CH_TAB     = 8'd9;
  localparam logic [CHAR_W-1:0] CH_NEWLINE = 8'd10;
  localparam logic [CHAR_W-1:0] CH_RETURN  = 8'd13;
  localparam logic [CHAR_W-1:0] CH_SPACE   = 8'd32;

  localparam logic [CHAR_W-1:0] ATTR_RESET = 8'h07;
  localparam logic [CELL_W-1:0] BLANK_CELL = 16'h0720;

  typedef struct packed {
    logic [1:0]        cmd;
    logic [CHAR_W-1:0] char_code;
    logic [CHAR_W-1:0] cell_attr;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
  } request_t;

  typedef struct packed {
    logic [COL_W-1:0]  cursor_col;
    logic [ROW_W-1:0]  cursor_row;
    logic [CELL_W-1:0] cell_value;
    logic              scrolled;
    logic              out_of_range;
  } result_t;

  typedef enum logic [2:0] {
    OP_PUT_CHAR,
    OP_NEWLINE,
    OP_RETURN,
    OP_TAB,
    OP_WRITE,
    OP_READ,
    OP_OOR,
    OP_NOP
  } op_kind_t;

  typedef struct packed {
    op_kind_t          kind;
    logic [CHAR_W-1:0] char_code;
    logic [CHAR_W-1:0] cell_attr;
    logic [COL_W-1:0]  pos_col;
    logic [ROW_W-1:0]  pos_row;
  } op_t;

  typedef enum logic [1:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_READ,
    ST_FILL
  } back_state_t;

endpackage

// ----- sv/twm_front.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_front
// Accepts request items, decodes them into operations and holds them in a
// two-entry queue for the execution side.
// ----------------------------------------------------------------------------
module twm_front #(
  parameter int COLUMNS = 80,
  parameter int ROWS    = 25
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              push,
  output logic              full,
  input  twm_pkg::request_t request,
  input  logic              hold,
  output logic              op_valid,
  output twm_pkg::op_t      op,
  input  logic              op_pop
);

  localparam int DEPTH = 2;
  localparam int PTR_W = $clog2(DEPTH);

  twm_pkg::op_t      q [DEPTH];
  logic [PTR_W-1:0]  wr_ptr;
  logic [PTR_W-1:0]  rd_ptr;
  logic [PTR_W:0]    count;
  twm_pkg::op_t      decoded;
  logic              accept;
  logic              take;
  logic              off_screen;

  assign off_screen = (request.pos_col >= twm_pkg::COL_W'(COLUMNS)) ||
                      (request.pos_row >= twm_pkg::ROW_W'(ROWS));

  always_comb begin
    decoded.char_code = request.char_code;
    decoded.cell_attr = request.cell_attr;
    decoded.pos_col   = request.pos_col;
    decoded.pos_row   = request.pos_row;
    case (request.cmd)
      twm_pkg::CMD_PUT: begin
        case (request.char_code)
          twm_pkg::CH_NEWLINE: decoded.kind = twm_pkg::OP_NEWLINE;
          twm_pkg::CH_RETURN:  decoded.kind = twm_pkg::OP_RETURN;
          twm_pkg::CH_TAB:     decoded.kind = twm_pkg::OP_TAB;
          default:             decoded.kind = twm_pkg::OP_PUT_CHAR;
        endcase
      end
      twm_pkg::CMD_WRITE: decoded.kind = off_screen ? twm_pkg::OP_OOR : twm_pkg::OP_WRITE;
      twm_pkg::CMD_READ:  decoded.kind = off_screen ? twm_pkg::OP_OOR : twm_pkg::OP_READ;
      default:            decoded.kind = twm_pkg::OP_NOP;
    endcase
  end

  assign full     = hold || (count == (PTR_W+1)'(DEPTH));
  assign accept   = push && !full;
  assign op_valid = (count != '0);
  assign take     = op_pop && op_valid;
  assign op       = q[rd_ptr];

  always_ff @(posedge clk) begin
    if (accept) begin
      q[wr_ptr] <= decoded;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (accept) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (take) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
      case ({accept, take})
        2'b10:   count <= count + 1'b1;
        2'b01:   count <= count - 1'b1;
        default: count <= count;
      endcase
    end
  end

endmodule

// ----- sv/twm_back.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// twm_back
// Executes decoded operations against the cell store, keeps the cursor and
// the ring offset of the top row, and holds one result for the consumer.
// ----------------------------------------------------------------------------
module twm_back #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       cfg_wr_en,
  input  logic [twm_pkg::CHAR_W-1:0] cfg_wr_data,
  input  logic                       op_valid,
  input  twm_pkg::op_t               op,
  output logic                       op_pop,
  output logic                       clearing,
  output logic                       empty,
  input  logic                       pop,
  output twm_pkg::result_t           result
);

  localparam int DEPTH   = ROWS * COLUMNS;
  localparam int ADDR_W  = $clog2(DEPTH);
  localparam int COL_W   = twm_pkg::COL_W;
  localparam int ROW_W   = twm_pkg::ROW_W;
  localparam int PHASE_W = $clog2(TAB_STOP);

  logic [twm_pkg::CELL_W-1:0] mem [DEPTH];

  twm_pkg::back_state_t       state;
  twm_pkg::back_state_t       state_next;
  logic [COL_W-1:0]           cur_col;
  logic [COL_W-1:0]           cur_col_next;
  logic [ROW_W-1:0]           cur_row;
  logic [ROW_W-1:0]           cur_row_next;
  logic [PHASE_W-1:0]         tab_phase;
  logic [PHASE_W-1:0]         tab_phase_next;
  logic [ROW_W-1:0]           top;
  logic [twm_pkg::CHAR_W-1:0] text_attr;
  logic [twm_pkg::CHAR_W-1:0] fill_attr;
  logic [ADDR_W-1:0]          clr_addr;
  logic [ADDR_W-1:0]          fill_addr;
  logic [COL_W-1:0]           fill_cnt;
  logic                       res_valid;
  twm_pkg::result_t           res;
  logic [twm_pkg::CELL_W-1:0] rd_data;

  logic                       slot_free;
  logic                       exec;
  logic                       res_load;
  twm_pkg::result_t           res_new;
  logic                       wr_en;
  logic [ADDR_W-1:0]          wr_addr;
  logic [twm_pkg::CELL_W-1:0] wr_data;
  logic                       rd_en;
  logic [ADDR_W-1:0]          rd_addr;
  logic                       scroll;
  logic                       at_last_row;
  logic [COL_W:0]             tab_col;

  // Map a screen row through the ring offset onto a store address.
  function automatic logic [ADDR_W-1:0] cell_addr(input logic [ROW_W-1:0] row,
                                                  input logic [COL_W-1:0] col,
                                                  input logic [ROW_W-1:0] base);
    logic [ROW_W:0] prow;
    prow = {1'b0, row} + {1'b0, base};
    if (prow >= (ROW_W+1)'(ROWS)) begin
      prow = prow - (ROW_W+1)'(ROWS);
    end
    return ADDR_W'(prow) * ADDR_W'(COLUMNS) + ADDR_W'(col);
  endfunction

  assign slot_free   = !res_valid || pop;
  assign exec        = (state == twm_pkg::ST_IDLE) && op_valid && slot_free;
  assign at_last_row = (cur_row == ROW_W'(ROWS - 1));
  assign tab_col     = {1'b0, cur_col} + (COL_W+1)'(TAB_STOP) - (COL_W+1)'(tab_phase);
  assign clearing    = (state == twm_pkg::ST_CLEAR);
  assign empty       = !res_valid;
  assign result      = res;

  always_comb begin
    state_next = state;
    case (state)
      twm_pkg::ST_CLEAR: begin
        if (clr_addr == ADDR_W'(DEPTH - 1)) begin
          state_next = twm_pkg::ST_IDLE;
        end
      end
      twm_pkg::ST_IDLE: begin
        if (exec && op.kind == twm_pkg::OP_READ) begin
          state_next = twm_pkg::ST_READ;
        end else if (exec && scroll) begin
          state_next = twm_pkg::ST_FILL;
        end
      end
      twm_pkg::ST_READ: begin
        if (slot_free) begin
          state_next = twm_pkg::ST_IDLE;
        end
      end
      twm_pkg::ST_FILL: begin
        if (fill_cnt == COL_W'(COLUMNS - 1)) begin
          state_next = twm_pkg::ST_IDLE;
        end
      end
      default: state_next = twm_pkg::ST_IDLE;
    endcase
  end

  always_comb begin
    op_pop         = 1'b0;
    res_load       = 1'b0;
    res_new        = '0;
    res_new.cursor_col = cur_col;
    res_new.cursor_row = cur_row;
    wr_en          = 1'b0;
    wr_addr        = cell_addr(cur_row, cur_col, top);
    wr_data        = {text_attr, op.char_code};
    rd_en          = 1'b0;
    rd_addr        = cell_addr(op.pos_row, op.pos_col, top);
    scroll         = 1'b0;
    cur_col_next   = cur_col;
    cur_row_next   = cur_row;
    tab_phase_next = tab_phase;

    case (state)
      twm_pkg::ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_addr = clr_addr;
        wr_data = twm_pkg::BLANK_CELL;
      end
      twm_pkg::ST_FILL: begin
        wr_en   = 1'b1;
        wr_addr = fill_addr;
        wr_data = {fill_attr, twm_pkg::CH_SPACE};
      end
      twm_pkg::ST_READ: begin
        if (slot_free) begin
          res_load           = 1'b1;
          res_new.cell_value = rd_data;
        end
      end
      twm_pkg::ST_IDLE: begin
        if (exec) begin
          op_pop   = 1'b1;
          res_load = 1'b1;
          case (op.kind)
            twm_pkg::OP_PUT_CHAR: begin
              wr_en              = 1'b1;
              res_new.cell_value = wr_data;
              if (cur_col == COL_W'(COLUMNS - 1)) begin
                cur_col_next   = '0;
                tab_phase_next = '0;
                scroll         = at_last_row;
                cur_row_next   = at_last_row ? cur_row : cur_row + 1'b1;
              end else begin
                cur_col_next   = cur_col + 1'b1;
                tab_phase_next = (tab_phase == PHASE_W'(TAB_STOP - 1)) ? '0
                                                                       : tab_phase + 1'b1;
              end
            end
            twm_pkg::OP_NEWLINE: begin
              cur_col_next   = '0;
              tab_phase_next = '0;
              scroll         = at_last_row;
              cur_row_next   = at_last_row ? cur_row : cur_row + 1'b1;
            end
            twm_pkg::OP_RETURN: begin
              cur_col_next   = '0;
              tab_phase_next = '0;
            end
            twm_pkg::OP_TAB: begin
              tab_phase_next = '0;
              if (tab_col >= (COL_W+1)'(COLUMNS)) begin
                // Tab stop off the right edge wraps like a full line
                cur_col_next = '0;
                scroll       = at_last_row;
                cur_row_next = at_last_row ? cur_row : cur_row + 1'b1;
              end else begin
                cur_col_next = tab_col[COL_W-1:0];
              end
            end
            twm_pkg::OP_WRITE: begin
              wr_en              = 1'b1;
              wr_addr            = rd_addr;
              wr_data            = {op.cell_attr, op.char_code};
              res_new.cell_value = wr_data;
            end
            twm_pkg::OP_READ: begin
              rd_en    = 1'b1;
              res_load = 1'b0;
            end
            twm_pkg::OP_OOR: begin
              res_new.out_of_range = 1'b1;
            end
            default: begin
            end
          endcase
          res_new.cursor_col = cur_col_next;
          res_new.cursor_row = cur_row_next;
          res_new.scrolled   = scroll;
        end
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      res <= res_new;
    end
    if (exec && scroll) begin
      // The old top row becomes the bottom row; hold the fill attribute
      fill_addr <= ADDR_W'(top) * ADDR_W'(COLUMNS);
      fill_attr <= text_attr;
    end else if (state == twm_pkg::ST_FILL) begin
      fill_addr <= fill_addr + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= twm_pkg::ST_CLEAR;
      cur_col   <= '0;
      cur_row   <= '0;
      tab_phase <= '0;
      top       <= '0;
      text_attr <= twm_pkg::ATTR_RESET;
      clr_addr  <= '0;
      fill_cnt  <= '0;
      res_valid <= 1'b0;
    end else begin
      state     <= state_next;
      cur_col   <= cur_col_next;
      cur_row   <= cur_row_next;
      tab_phase <= tab_phase_next;
      if (cfg_wr_en) begin
        text_attr <= cfg_wr_data;
      end
      if (state == twm_pkg::ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
      if (exec && scroll) begin
        top      <= (top == ROW_W'(ROWS - 1)) ? '0 : top + 1'b1;
        fill_cnt <= '0;
      end else if (state == twm_pkg::ST_FILL) begin
        fill_cnt <= fill_cnt + 1'b1;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (pop) begin
        res_valid <= 1'b0;
      end
    end
  end

endmodule

// ----- sv/text_mode_terminal_writer.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// text_mode_terminal_writer
// Character terminal over a COLUMNS x ROWS store of attribute/character cells.
//
//   channel   signals                   moves
//   request   push, full, request       one command item
//   result    empty, pop, result        one result item per command
//   config    cfg_wr_en, cfg_wr_data    text attribute register
//
// A put, control, write-cell or off-screen item passes through the decode
// queue and is executed into the registered result slot; a read also waits in
// the READ state for the registered store read. A scroll moves a ring offset
// and then blanks one row, one cell at a time on the single store write port.
// After reset the store is swept to blank cells, all ROWS*COLUMNS of them,
// while full stays high. A result waiting on pop holds the executor; the
// decode queue keeps taking up to two items meanwhile.
// ----------------------------------------------------------------------------
module text_mode_terminal_writer #(
  parameter int COLUMNS  = 80,
  parameter int ROWS     = 25,
  parameter int TAB_STOP = 8
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       push,
  output logic                       full,
  input  twm_pkg::request_t          request,
  output logic                       empty,
  input  logic                       pop,
  output twm_pkg::result_t           result,
  input  logic                       cfg_wr_en,
  input  logic [twm_pkg::CHAR_W-1:0] cfg_wr_data
);

  logic         op_valid;
  logic         op_pop;
  logic         clearing;
  twm_pkg::op_t op;

  twm_front #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_front (
    .clk      (clk),
    .rst      (rst),
    .push     (push),
    .full     (full),
    .request  (request),
    .hold     (clearing),
    .op_valid (op_valid),
    .op       (op),
    .op_pop   (op_pop)
  );

  twm_back #(
    .COLUMNS  (COLUMNS),
    .ROWS     (ROWS),
    .TAB_STOP (TAB_STOP)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data),
    .op_valid    (op_valid),
    .op          (op),
    .op_pop      (op_pop),
    .clearing    (clearing),
    .empty       (empty),
    .pop         (pop),
    .result      (result)
  );

endmodule

// ----- sim/testbench.sv -----
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the text mode terminal writer. A scoreboard keeps
// its own copy of the screen, cursor and text attribute, predicts one result
// per accepted command and compares it field by field with what the block
// returns. Stimulus is a short directed run, then random phases with
// different text attributes and sender/receiver idling.
// ----------------------------------------------------------------------------
module testbench;

  localparam int COLS          = 80;
  localparam int LINES         = 25;
  localparam int TAB_W         = 8;
  localparam logic [1:0] CMD_NONE = 2'd3;
  localparam int SETTLE_CYCLES = 3 * COLS;
  localparam int PHASES        = 5;
  localparam int PHASE_ITEMS   = 226;
  localparam int MAX_REPORTS   = 10;

  class terminal_scoreboard;
    logic [twm_pkg::CELL_W-1:0] screen [COLS*LINES];
    int                         col;
    int                         row;
    logic [twm_pkg::CHAR_W-1:0] attr;
    twm_pkg::result_t           expected_q[$];
    int                         errors;

    function new();
      foreach (screen[i]) screen[i] = twm_pkg::BLANK_CELL;
      col    = 0;
      row    = 0;
      attr   = twm_pkg::ATTR_RESET;
      errors = 0;
    endfunction

    function void set_attr(logic [twm_pkg::CHAR_W-1:0] value);
      attr = value;
    endfunction

    function int pending();
      return expected_q.size();
    endfunction

    // Move to the start of the next line; scroll when past the bottom row.
    function logic next_line();
      int i;
      col = 0;
      row++;
      if (row < LINES) return 1'b0;
      row = LINES - 1;
      for (i = 0; i < (LINES - 1) * COLS; i++) screen[i] = screen[i+COLS];
      for (i = 0; i < COLS; i++) screen[(LINES-1)*COLS+i] = {attr, twm_pkg::CH_SPACE};
      return 1'b1;
    endfunction

    function void note_request(twm_pkg::request_t item);
      twm_pkg::result_t exp_r;
      int               next_col;
      int               idx;
      exp_r = '0;
      idx   = int'(item.pos_row) * COLS + int'(item.pos_col);
      case (item.cmd)
        twm_pkg::CMD_PUT: begin
          if (item.char_code == twm_pkg::CH_NEWLINE) begin
            exp_r.scrolled = next_line();
          end else if (item.char_code == twm_pkg::CH_RETURN) begin
            col = 0;
          end else if (item.char_code == twm_pkg::CH_TAB) begin
            next_col = col + TAB_W - (col % TAB_W);
            if (next_col >= COLS) exp_r.scrolled = next_line();
            else col = next_col;
          end else begin
            exp_r.cell_value = {attr, item.char_code};
            screen[row*COLS+col] = exp_r.cell_value;
            col++;
            if (col >= COLS) exp_r.scrolled = next_line();
          end
        end
        twm_pkg::CMD_WRITE, twm_pkg::CMD_READ: begin
          if (int'(item.pos_col) >= COLS || int'(item.pos_row) >= LINES) begin
            exp_r.out_of_range = 1'b1;
          end else if (item.cmd == twm_pkg::CMD_WRITE) begin
            exp_r.cell_value = {item.cell_attr, item.char_code};
            screen[idx] = exp_r.cell_value;
          end else begin
            exp_r.cell_value = screen[idx];
          end
        end
        default: ;
      endcase
      exp_r.cursor_col = twm_pkg::COL_W'(col);
      exp_r.cursor_row = twm_pkg::ROW_W'(row);
      expected_q.push_back(exp_r);
    endfunction

    function void flag(string what, logic [31:0] exp_v, logic [31:0] got_v);
      errors++;
      if (errors <= MAX_REPORTS)
        $display("[%0t] %s: expected %0h, got %0h", $time, what, exp_v, got_v);
    endfunction

    function void compare(string what, logic [31:0] exp_v, logic [31:0] got_v);
      if (exp_v !== got_v) flag(what, exp_v, got_v);
    endfunction

    function void check_result(twm_pkg::result_t got);
      twm_pkg::result_t exp_r;
      if (expected_q.size() == 0) begin
        flag("result with no command outstanding", 32'd0, 32'(got));
        return;
      end
      exp_r = expected_q.pop_front();
      compare("cursor_col", 32'(exp_r.cursor_col), 32'(got.cursor_col));
      compare("cursor_row", 32'(exp_r.cursor_row), 32'(got.cursor_row));
      compare("cell_value", 32'(exp_r.cell_value), 32'(got.cell_value));
      compare("scrolled", 32'(exp_r.scrolled), 32'(got.scrolled));
      compare("out_of_range", 32'(exp_r.out_of_range), 32'(got.out_of_range));
    endfunction
  endclass

  logic                       clk         = 1'b0;
  logic                       rst         = 1'b1;
  logic                       push        = 1'b0;
  logic                       full;
  twm_pkg::request_t          request     = '0;
  logic                       empty;
  logic                       pop         = 1'b0;
  twm_pkg::result_t           result;
  logic                       cfg_wr_en   = 1'b0;
  logic [twm_pkg::CHAR_W-1:0] cfg_wr_data = '0;

  int                 tx_idle_pct  = 0;
  int                 rx_stall_pct = 0;
  terminal_scoreboard sb           = new();

  text_mode_terminal_writer #(
    .COLUMNS  (COLS),
    .ROWS     (LINES),
    .TAB_STOP (TAB_W)
  ) u_dut (
    .clk         (clk),
    .rst         (rst),
    .push        (push),
    .full        (full),
    .request     (request),
    .empty       (empty),
    .pop         (pop),
    .result      (result),
    .cfg_wr_en   (cfg_wr_en),
    .cfg_wr_data (cfg_wr_data)
  );

  always #1 clk = ~clk;

  always @(posedge clk) begin
    pop <= ($urandom_range(99) >= rx_stall_pct);
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) sb.check_result(result);
  end

  function automatic twm_pkg::request_t make_request(logic [1:0] cmd,
                                                     logic [twm_pkg::CHAR_W-1:0] ch,
                                                     logic [twm_pkg::CHAR_W-1:0] at,
                                                     logic [twm_pkg::COL_W-1:0] c,
                                                     logic [twm_pkg::ROW_W-1:0] r);
    twm_pkg::request_t item;
    item.cmd       = cmd;
    item.char_code = ch;
    item.cell_attr = at;
    item.pos_col   = c;
    item.pos_row   = r;
    return item;
  endfunction

  // Mostly printable text with line control, some cell traffic, a little noise.
  function automatic twm_pkg::request_t random_request();
    twm_pkg::request_t item;
    logic [31:0]       bits;
    int                pick;
    bits           = $urandom;
    item           = bits[$bits(twm_pkg::request_t)-1:0];
    item.cmd       = twm_pkg::CMD_PUT;
    item.char_code = twm_pkg::CHAR_W'($urandom_range(32, 126));
    pick           = $urandom_range(99);
    if (pick < 6) begin
      item.char_code = twm_pkg::CHAR_W'($urandom);
    end else if (pick < 55) begin
      item.cmd = twm_pkg::CMD_PUT;
    end else if (pick < 63) begin
      item.char_code = twm_pkg::CH_NEWLINE;
    end else if (pick < 67) begin
      item.char_code = twm_pkg::CH_TAB;
    end else if (pick < 69) begin
      item.char_code = twm_pkg::CH_RETURN;
    end else if (pick < 96) begin
      item.cmd = $urandom_range(1) ? twm_pkg::CMD_WRITE : twm_pkg::CMD_READ;
      // keep most cell accesses on screen, often on the cursor line
      if (pick < 91) begin
        item.pos_col = twm_pkg::COL_W'($urandom_range(COLS - 1));
        item.pos_row = $urandom_range(1) ? twm_pkg::ROW_W'(sb.row)
                                         : twm_pkg::ROW_W'($urandom_range(LINES - 1));
      end
    end else begin
      item.cmd = CMD_NONE;
    end
    return item;
  endfunction

  task automatic send_item(twm_pkg::request_t item);
    while (tx_idle_pct != 0 && $urandom_range(99) < tx_idle_pct) begin
      push <= 1'b0;
      @(posedge clk);
    end
    request <= item;
    push    <= 1'b1;
    @(posedge clk);
    while (full) @(posedge clk);
    sb.note_request(item);
  endtask

  task automatic drain_results();
    push <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
  endtask

  // Let a trailing scroll fill finish before touching the attribute.
  task automatic write_attr(logic [twm_pkg::CHAR_W-1:0] value);
    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    cfg_wr_en   <= 1'b1;
    cfg_wr_data <= value;
    @(posedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_attr(value);
  endtask

  initial begin
    #2_000_000;
    $display("Mismatches found");
    $finish;
  end

  initial begin
    twm_pkg::request_t          directed_q[$];
    logic [twm_pkg::CHAR_W-1:0] phase_attr;
    int                         mode;
    int                         p;
    int                         i;

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    directed_q.push_back(make_request(twm_pkg::CMD_PUT, 8'h00, 8'h00, 7'h00, 5'h00));
    directed_q.push_back(make_request(twm_pkg::CMD_PUT, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
    directed_q.push_back(make_request(twm_pkg::CMD_PUT, twm_pkg::CH_RETURN, 8'h00,
                                      7'h00, 5'h00));
    directed_q.push_back(make_request(twm_pkg::CMD_PUT, twm_pkg::CH_NEWLINE, 8'h00,
                                      7'h00, 5'h00));
    // ten tabs: stops at 8..72, the last one wraps to the next line
    for (i = 0; i < 10; i++)
      directed_q.push_back(make_request(twm_pkg::CMD_PUT, twm_pkg::CH_TAB, 8'h00,
                                        7'h00, 5'h00));
    directed_q.push_back(make_request(twm_pkg::CMD_WRITE, 8'hFF, 8'hFF, 7'd0, 5'd0));
    directed_q.push_back(make_request(twm_pkg::CMD_WRITE, 8'h00, 8'h00, 7'(COLS - 1),
                                      5'(LINES - 1)));
    directed_q.push_back(make_request(twm_pkg::CMD_READ, 8'h00, 8'h00, 7'(COLS - 1),
                                      5'(LINES - 1)));
    directed_q.push_back(make_request(twm_pkg::CMD_READ, 8'h00, 8'h00, 7'd0, 5'd0));
    directed_q.push_back(make_request(twm_pkg::CMD_WRITE, 8'h41, 8'h1E, 7'h7F, 5'd0));
    directed_q.push_back(make_request(twm_pkg::CMD_READ, 8'h00, 8'h00, 7'(COLS),
                                      5'(LINES - 1)));
    directed_q.push_back(make_request(twm_pkg::CMD_WRITE, 8'h42, 8'hE1, 7'd0, 5'h1F));
    directed_q.push_back(make_request(twm_pkg::CMD_READ, 8'h00, 8'h00, 7'(COLS - 1),
                                      5'(LINES)));
    directed_q.push_back(make_request(CMD_NONE, 8'hFF, 8'hFF, 7'h7F, 5'h1F));
    directed_q.push_back(make_request(twm_pkg::CMD_READ, 8'h00, 8'h00, 7'd5, 5'd5));
    foreach (directed_q[k]) send_item(directed_q[k]);

    for (p = 0; p < PHASES; p++) begin
      phase_attr = (p == 0) ? 8'h00 : (p == 1) ? 8'hFF : twm_pkg::CHAR_W'($urandom);
      write_attr(phase_attr);
      mode         = p % 4;
      tx_idle_pct  = (mode == 1) ? 57 : (mode == 3) ? 23 : 0;
      rx_stall_pct = (mode == 2) ? 57 : (mode == 3) ? 23 : 0;
      for (i = 0; i < PHASE_ITEMS; i++) begin
        send_item(random_request());
        // hold the sender once until the block has fully caught up
        if (p == 2 && i == PHASE_ITEMS / 2) drain_results();
      end
    end

    drain_results();
    repeat (SETTLE_CYCLES) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
